// File: sv/dsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dsn_pkg;
    localparam logic [31:0] NARROW_NAN  = 32'h7fff_ffff;
    localparam logic [31:0] NARROW_INF  = 32'h7f80_0000;
    localparam logic [22:0] NARROW_MANT = 23'h7f_ffff;
    localparam logic [10:0] EFIELD_MAX  = 11'h7ff;
    // Biased binary64 field values: e = efield - 1022.
    localparam logic [10:0] EF_OVF_ABOVE = 11'd1150;  // e > 128
    localparam logic [10:0] EF_NORM_MIN  = 11'd897;   // e >= -125
    localparam logic [10:0] EF_SUB_LOW   = 11'd874;   // e = -148

    localparam logic [2:0] CLS_NAN  = 3'd0;
    localparam logic [2:0] CLS_INF  = 3'd1;
    localparam logic [2:0] CLS_PZERO = 3'd2;
    localparam logic [2:0] CLS_SZERO = 3'd3;
    localparam logic [2:0] CLS_NORM = 3'd4;
    localparam logic [2:0] CLS_SUB  = 3'd5;

    typedef struct packed {
        logic        sign;
        logic [2:0]  cls;
        logic [7:0]  exp;
        logic [52:0] sig;
        logic [5:0]  shift;
    } dsn_cls_t;
endpackage
`default_nettype wire

// File: sv/dsn_classify.sv
`timescale 1ns / 1ps
`default_nettype none
module dsn_classify (
    input  wire logic [63:0]      wide_bits,
    output dsn_pkg::dsn_cls_t     cls
);
    import dsn_pkg::*;
    logic [10:0] ef;
    logic [51:0] mant;
    logic [10:0] sh;
    always_comb
    begin
        ef = wide_bits[62:52];
        mant = wide_bits[51:0];
        sh = 11'd926 - ef;  // -96 - e
        cls.sign = wide_bits[63];
        cls.sig = {1'b1, mant};
        cls.exp = 8'(ef - 11'd896);  // e + 126
        cls.shift = sh[5:0];
        if (ef == EFIELD_MAX)
            cls.cls = (mant != '0) ? CLS_NAN : CLS_INF;
        else if (ef == '0)
            cls.cls = (mant == '0) ? CLS_PZERO : CLS_SZERO;
        else if (ef > EF_OVF_ABOVE)
            cls.cls = CLS_INF;
        else if (ef >= EF_NORM_MIN)
            cls.cls = CLS_NORM;
        else if (ef >= EF_SUB_LOW)
            cls.cls = CLS_SUB;
        else
            cls.cls = CLS_SZERO;
    end
endmodule
`default_nettype wire

// File: sv/dsn_shift.sv
`timescale 1ns / 1ps
`default_nettype none
// Coarse and fine halves of the subnormal right shift (30..52).
module dsn_shift (
    input  wire logic [52:0] sig,
    input  wire logic [5:0]  shift,
    input  wire logic        fine,
    output logic [52:0]      res
);
    always_comb
    begin
        if (fine)
            res = sig >> shift[2:0];
        else
            res = sig >> {shift[5:3], 3'b000};
    end
endmodule
`default_nettype wire

// File: sv/double_to_single_narrowing_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Truncating binary64 to binary32 converter. It accepts one request per cycle
// while the output is not stalled; the pipeline is classify, coarse
// shift, fine shift with result assembly, and a stall holds all stages.
module double_to_single_narrowing_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] wide_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      narrow_bits
);
    import dsn_pkg::*;
    logic advance;
    logic v1_reg, v2_reg, v3_reg;
    dsn_cls_t c_next, c1_reg, c2_next, c2_reg;
    logic [52:0] sh1, sh2;
    logic [31:0] res_next, res_reg;

    assign advance = !v3_reg || out_ready;
    assign in_ready = advance;

    dsn_classify u_cls (.wide_bits(wide_bits), .cls(c_next));
    dsn_shift u_coarse (.sig(c1_reg.sig), .shift(c1_reg.shift), .fine(1'b0), .res(sh1));
    dsn_shift u_fine (.sig(c2_reg.sig), .shift(c2_reg.shift), .fine(1'b1), .res(sh2));

    always_comb
    begin
        c2_next = c1_reg;
        if (c1_reg.cls == CLS_SUB)
            c2_next.sig = sh1;
    end

    always_comb
    begin
        case (c2_reg.cls)
            CLS_NAN:   res_next = NARROW_NAN;
            CLS_INF:   res_next = NARROW_INF | {c2_reg.sign, 31'd0};
            CLS_PZERO: res_next = '0;
            CLS_NORM:  res_next = {c2_reg.sign, c2_reg.exp, c2_reg.sig[51:29] & NARROW_MANT};
            CLS_SUB:   res_next = {c2_reg.sign, sh2[30:0]};
            default:   res_next = {c2_reg.sign, 31'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_reg <= c_next;
            c2_reg <= c2_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign narrow_bits = res_reg;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(narrow_bits))
        else $error("result changed under stall");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 in_ready [*2] |=> out_valid)
        else $error("request lost in pipeline");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");
`endif
endmodule
`default_nettype wire

// File: dv/narrowing_checker.sv
`timescale 1ns / 1ps
module narrowing_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] wide_bits,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] narrow_bits,
    output int          fail_count,
    output int          pending
);
    import dsn_pkg::*;

    logic [31:0] expected_narrow[$];

    function automatic logic [31:0] truncate_to_single(input logic [63:0] w);
        logic        sgn;
        logic [10:0] ef;
        logic [51:0] frac;
        logic [52:0] sig;
        int          e;
        logic [31:0] res;
        sgn  = w[63];
        ef   = w[62:52];
        frac = w[51:0];
        if (ef == EFIELD_MAX)
            return (frac != 0) ? NARROW_NAN : (NARROW_INF | {sgn, 31'd0});
        if (ef == 0)
            return (frac == 0) ? 32'd0 : {sgn, 31'd0};
        e = int'(ef) - 1022;
        if (e > 128)
            res = NARROW_INF;
        else if (e >= -125)
            res = {1'b0, 8'(e + 126), frac[51:29]};
        else if (e > -149)
        begin
            // Subnormal: the full significand shifts right by 30 to 52 places.
            sig = {1'b1, frac};
            res = 32'(sig >> (-96 - e));
        end
        else
            res = 32'd0;
        return res | {sgn, 31'd0};
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("narrowing_checker: %s got %h expected %h at %0t", what, got, exp_v, $realtime);
        fail_count++;
    endtask

    assign pending = expected_narrow.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_narrow.push_back(truncate_to_single(wide_bits));
            if (out_valid && out_ready)
            begin
                if (expected_narrow.size() == 0)
                    report("unexpected result", narrow_bits, 32'd0);
                else if (narrow_bits !== expected_narrow[0])
                    report("narrow_bits mismatch", narrow_bits, expected_narrow.pop_front());
                else
                    void'(expected_narrow.pop_front());
            end
        end
    end
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] wide_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] narrow_bits;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic        sink_active;

    localparam int WATCHDOG_LIMIT = 2000;

    double_to_single_narrowing_unit u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .wide_bits(wide_bits), .out_valid(out_valid), .out_ready(out_ready),
        .narrow_bits(narrow_bits)
    );

    narrowing_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .wide_bits(wide_bits), .out_valid(out_valid), .out_ready(out_ready),
        .narrow_bits(narrow_bits), .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly exponent fields near the interesting boundaries, with random content.
    function automatic logic [63:0] random_double();
        logic [10:0] ef;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 15)
            ef = 11'($urandom_range(0, 2047));
        else if (r < 40)
            ef = 11'($urandom_range(860, 910));
        else if (r < 55)
            ef = 11'($urandom_range(1140, 1160));
        else if (r < 65)
            ef = ($urandom_range(0, 1)) ? 11'h7ff : 11'h000;
        else
            ef = 11'($urandom_range(897, 1150));
        return {1'($urandom_range(0, 1)), ef, 20'($urandom), 32'($urandom)};
    endfunction

    // The request stays valid after acceptance unless a gap follows, so valid
    // is never assigned twice in one time step.
    task automatic send_request(input logic [63:0] value);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        wide_bits <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Receiver stalls run on their own.
    always @(posedge clk)
    begin
        if (sink_active)
            out_ready <= ($urandom_range(0, 99) < 12) ? 1'b0 :
                         ($urandom_range(0, 99) < 4) ? 1'b0 : 1'b1;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    logic [63:0] directed_values[$] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
        64'h7ff8_0000_0000_0000, 64'hfff0_0000_0000_0001, 64'h7fff_ffff_ffff_ffff,
        64'h0000_0000_0000_0001, 64'h800f_ffff_ffff_ffff,
        64'h47ff_ffff_ffff_ffff, 64'hc800_0000_0000_0000, 64'h7fef_ffff_ffff_ffff,
        64'h3810_0000_0000_0000, 64'hb80f_ffff_ffff_ffff,
        64'h36b0_0000_0000_0000, 64'hb6af_ffff_ffff_ffff, 64'h36a0_0000_0000_0000,
        64'h3ff0_0000_0000_0000, 64'hbff5_5555_5555_5555, 64'h4009_21fb_5444_2d18,
        64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa
    };

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        wide_bits   = '0;
        out_ready   = 1'b1;
        sink_active = 1'b0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_request(directed_values[i]);
        sink_active <= 1'b1;
        for (int n = 0; n < 1200; n++)
        begin
            send_request(random_double());
            if (n == 600)
            begin
                // Let the pipeline drain completely before carrying on.
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
